FILE: rtl/dfd_pkg.sv
// Shared types and constants for the detector frame feature decoder.
`default_nettype none
package dfd_pkg;

    localparam int CALO_CHANNELS       = 26;
    localparam int CRYSTAL_CHANNELS    = 8;
    localparam int SAMPLES_PER_CHANNEL = 128;
    localparam int PEDESTAL_SAMPLES    = 16;

    localparam int PED_COUNT   = (PEDESTAL_SAMPLES < SAMPLES_PER_CHANNEL) ?
                                 PEDESTAL_SAMPLES : SAMPLES_PER_CHANNEL;
    localparam int STORE_DEPTH = (CALO_CHANNELS > CRYSTAL_CHANNELS) ?
                                 CALO_CHANNELS : CRYSTAL_CHANNELS;
    localparam int CH_W        = $clog2(STORE_DEPTH + 1);
    localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int POS_W       = $clog2(SAMPLES_PER_CHANNEL * 2);
    localparam int SUM_W       = 16 + $clog2(PED_COUNT + 1);

    localparam logic [15:0] LEN_CALO_WAVE = 16'(CALO_CHANNELS * SAMPLES_PER_CHANNEL * 2 + 12);
    localparam logic [15:0] LEN_CALO_SUM  = 16'(CALO_CHANNELS * 4 + 12);
    localparam logic [15:0] LEN_CRY_WAVE  = 16'(CRYSTAL_CHANNELS * SAMPLES_PER_CHANNEL * 2 + 12);
    localparam logic [15:0] LEN_CRY_SUM   = 16'(CRYSTAL_CHANNELS * 4 + 12);

    localparam logic [23:0] SYNC_HEAD = 24'h55AAEB;
    localparam logic [7:0]  SYNC_LAST = 8'h90;
    localparam logic [7:0]  TRAILER_0 = 8'h5A;
    localparam logic [7:0]  TRAILER_1 = 8'hA5;

    localparam logic [1:0] KIND_CALO_WAVE = 2'd0;
    localparam logic [1:0] KIND_CALO_SUM  = 2'd1;
    localparam logic [1:0] KIND_CRY_WAVE  = 2'd2;
    localparam logic [1:0] KIND_CRY_SUM   = 2'd3;

    localparam logic [3:0] HDR_LEN_HI = 4'd2;
    localparam logic [3:0] HDR_LEN_LO = 4'd3;
    localparam logic [3:0] HDR_FEE   = 4'd11;

    localparam logic [3:0] TAIL_TRIG_HI = 4'd0;
    localparam logic [3:0] TAIL_TRIG_LO = 4'd1;
    localparam logic [3:0] TAIL_TRL_0   = 4'd6;
    localparam logic [3:0] TAIL_TRL_1   = 4'd7;
    localparam logic [3:0] TAIL_MM_0    = 4'd8;
    localparam logic [3:0] TAIL_END     = 4'd11;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_BODY,
        PH_TAIL
    } phase_t;

    typedef enum logic {
        BK_IDLE,
        BK_DRAIN
    } back_state_t;

    typedef struct packed {
        logic [7:0]  fee_byte;
        logic [1:0]  kind;
        logic [11:0] trigger;
        logic [31:0] mm_trigger;
    } desc_t;

    typedef struct packed {
        logic             wr_hi;
        logic             wr_lo;
        logic [IDX_W-1:0] idx;
        logic [15:0]      hi;
        logic [15:0]      lo;
    } store_wr_t;

    function automatic logic [CH_W-1:0] kind_channels(input logic [1:0] kind);
        return kind[1] ? CH_W'(CRYSTAL_CHANNELS) : CH_W'(CALO_CHANNELS);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/dfd_front.sv
// Front part: sync hunt, header and body parsing, channel feature extraction.
`default_nettype none
module dfd_front
    import dfd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_fire,
    input  wire logic [7:0] in_byte,
    output store_wr_t      store_wr,
    output logic           desc_push,
    output desc_t          desc
);

    phase_t               phase_reg, phase_next;
    logic [23:0]          sync_reg, sync_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic [15:0]          len_reg, len_next;
    logic [7:0]           fee_reg, fee_next;
    logic [1:0]           kind_reg, kind_next;
    logic [7:0]           high_reg, high_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [15:0]          max_reg, max_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [CH_W-1:0]      chan_reg, chan_next;
    logic [11:0]          trig_reg, trig_next;
    logic                 trl_reg, trl_next;
    logic [31:0]          mm_reg, mm_next;

    logic                 wave;
    logic [CH_W-1:0]      nch;
    logic [POS_W-1:0]     pos_last;
    logic [15:0]          v;
    logic [POS_W-2:0]     s;
    logic [15:0]          len_full;
    logic                 len_ok;
    logic [3:0]           fee_nib;
    logic                 fee_calo, fee_cry;
    logic                 kind_ok;
    logic [1:0]           kind_new;
    logic [SUM_W-1:0]     sum_upd;
    logic [15:0]          max_upd;
    logic                 trl_fail;

    always_comb begin
        wave     = !kind_reg[0];
        nch      = kind_channels(kind_reg);
        pos_last = wave ? POS_W'(SAMPLES_PER_CHANNEL * 2 - 1) : POS_W'(3);
        v        = {high_reg, in_byte};
        s        = pos_reg[POS_W-1:1];
        len_full = {len_reg[15:8], in_byte};
        len_ok   = (len_full == LEN_CALO_WAVE) || (len_full == LEN_CALO_SUM) ||
                   (len_full == LEN_CRY_WAVE) || (len_full == LEN_CRY_SUM);
        fee_nib  = in_byte[7:4];
        fee_calo = (fee_nib >= 4'd5) && (fee_nib <= 4'd8);
        fee_cry  = (fee_nib == 4'd2);
        kind_ok  = 1'b0;
        kind_new = KIND_CALO_WAVE;
        if (fee_calo) begin
            if (len_reg == LEN_CALO_WAVE) begin
                kind_ok = 1'b1; kind_new = KIND_CALO_WAVE;
            end else if (len_reg == LEN_CALO_SUM) begin
                kind_ok = 1'b1; kind_new = KIND_CALO_SUM;
            end
        end else if (fee_cry) begin
            if (len_reg == LEN_CRY_WAVE) begin
                kind_ok = 1'b1; kind_new = KIND_CRY_WAVE;
            end else if (len_reg == LEN_CRY_SUM) begin
                kind_ok = 1'b1; kind_new = KIND_CRY_SUM;
            end
        end
        sum_upd  = (s == '0) ? SUM_W'(v) : sum_reg + SUM_W'(v);
        max_upd  = ((s == '0) || (v > max_reg)) ? v : max_reg;
        trl_fail = wave && !(trl_reg && (in_byte == TRAILER_1));
    end

    always_comb begin
        phase_next = phase_reg;
        if (in_fire) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    if (sync_reg == SYNC_HEAD && in_byte == SYNC_LAST) begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_HEADER: begin
                    if (cnt_reg == HDR_LEN_LO && !len_ok) begin
                        phase_next = PH_HUNT;
                    end else if (cnt_reg == HDR_FEE) begin
                        phase_next = kind_ok ? PH_BODY : PH_HUNT;
                    end
                end
                PH_BODY: begin
                    if (pos_reg == pos_last && chan_reg + CH_W'(1) == nch) begin
                        phase_next = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    if ((cnt_reg == TAIL_TRL_1 && trl_fail) || cnt_reg == TAIL_END) begin
                        phase_next = PH_HUNT;
                    end
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    always_comb begin
        sync_next = sync_reg;
        cnt_next  = cnt_reg;
        len_next  = len_reg;
        fee_next  = fee_reg;
        kind_next = kind_reg;
        high_next = high_reg;
        sum_next  = sum_reg;
        max_next  = max_reg;
        pos_next  = pos_reg;
        chan_next = chan_reg;
        trig_next = trig_reg;
        trl_next  = trl_reg;
        mm_next   = mm_reg;
        store_wr  = '{wr_hi: 1'b0, wr_lo: 1'b0, idx: chan_reg[IDX_W-1:0],
                      hi: v, lo: v};
        desc_push = 1'b0;
        desc      = '{fee_byte: fee_reg, kind: kind_reg, trigger: trig_reg,
                      mm_trigger: {mm_reg[23:0], in_byte}};
        if (in_fire) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    sync_next = {sync_reg[15:0], in_byte};
                    cnt_next  = '0;
                end
                PH_HEADER: begin
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == HDR_LEN_HI) begin
                        len_next = {in_byte, 8'h00};
                    end else if (cnt_reg == HDR_LEN_LO) begin
                        len_next = len_full;
                        if (!len_ok) begin
                            sync_next = '0;
                        end
                    end else if (cnt_reg == HDR_FEE) begin
                        fee_next  = in_byte;
                        sync_next = '0;
                        if (kind_ok) begin
                            kind_next = kind_new;
                        end
                        pos_next  = '0;
                        chan_next = '0;
                    end
                end
                PH_BODY: begin
                    pos_next = (pos_reg == pos_last) ? '0 : pos_reg + POS_W'(1);
                    if (pos_reg == pos_last) begin
                        chan_next = chan_reg + CH_W'(1);
                    end
                    cnt_next = '0;
                    if (!pos_reg[0]) begin
                        high_next = in_byte;
                    end else if (wave) begin
                        if (s < (POS_W-1)'(PED_COUNT)) begin
                            sum_next = sum_upd;
                        end else if (s == '0) begin
                            sum_next = '0;
                        end
                        max_next = max_upd;
                        if (pos_reg == pos_last) begin
                            store_wr.wr_hi = 1'b1;
                            store_wr.wr_lo = 1'b1;
                            store_wr.hi    = 16'(((s < (POS_W-1)'(PED_COUNT)) ? sum_upd
                                                   : sum_reg) / PED_COUNT);
                            store_wr.lo    = max_upd;
                        end
                    end else begin
                        store_wr.wr_hi = !pos_reg[1];
                        store_wr.wr_lo = pos_reg[1];
                    end
                end
                PH_TAIL: begin
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == TAIL_TRIG_HI) begin
                        trig_next = {in_byte[3:0], 8'h00};
                    end else if (cnt_reg == TAIL_TRIG_LO) begin
                        trig_next = {trig_reg[11:8], in_byte};
                    end else if (cnt_reg == TAIL_TRL_0) begin
                        trl_next = (in_byte == TRAILER_0);
                    end else if (cnt_reg >= TAIL_MM_0) begin
                        mm_next = {mm_reg[23:0], in_byte};
                    end
                    if (cnt_reg == TAIL_TRL_1 && trl_fail) begin
                        sync_next = '0;
                        cnt_next  = '0;
                    end
                    if (cnt_reg == TAIL_END) begin
                        desc_push = 1'b1;
                        sync_next = '0;
                        cnt_next  = '0;
                    end
                end
                default: cnt_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            sync_reg  <= '0;
            cnt_reg   <= '0;
            len_reg   <= '0;
            fee_reg   <= '0;
            kind_reg  <= '0;
            high_reg  <= '0;
            sum_reg   <= '0;
            max_reg   <= '0;
            pos_reg   <= '0;
            chan_reg  <= '0;
            trig_reg  <= '0;
            trl_reg   <= 1'b0;
            mm_reg    <= '0;
        end else begin
            phase_reg <= phase_next;
            sync_reg  <= sync_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            fee_reg   <= fee_next;
            kind_reg  <= kind_next;
            high_reg  <= high_next;
            sum_reg   <= sum_next;
            max_reg   <= max_next;
            pos_reg   <= pos_next;
            chan_reg  <= chan_next;
            trig_reg  <= trig_next;
            trl_reg   <= trl_next;
            mm_reg    <= mm_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/dfd_queue.sv
// Two-entry queue of finished packet descriptors between front and back.
`default_nettype none
module dfd_queue
    import dfd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  desc_t     push_desc,
    input  wire logic pop,
    output logic      not_empty,
    output desc_t     head
);

    desc_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb begin
        not_empty   = (count_reg != 2'd0);
        head        = entry_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (pop && not_empty);
        count_next  = count_reg + 2'(push) - 2'(pop && not_empty);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/dfd_back.sv
// Back part: channel result store and per-channel result drain.
`default_nettype none
module dfd_back
    import dfd_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  store_wr_t         store_wr,
    input  wire logic         desc_valid,
    input  desc_t             desc_in,
    output logic              desc_pop,
    output logic              busy,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    logic [15:0]      hi_mem [STORE_DEPTH];
    logic [15:0]      lo_mem [STORE_DEPTH];

    back_state_t      state_reg, state_next;
    desc_t            desc_reg, desc_next;
    logic [CH_W-1:0]  cnt_reg, cnt_next;
    logic             valid_reg, valid_next;
    logic [95:0]      data_reg, data_next;
    logic [1:0]       user_reg, user_next;
    logic             last_reg, last_next;

    logic             out_free;
    logic             is_last;
    logic [4:0]       ch5;

    always_ff @(posedge aclk) begin
        if (store_wr.wr_hi) begin
            hi_mem[store_wr.idx] <= store_wr.hi;
        end
        if (store_wr.wr_lo) begin
            lo_mem[store_wr.idx] <= store_wr.lo;
        end
    end

    always_comb begin
        out_free = !valid_reg || m_tready;
        is_last  = (cnt_reg + CH_W'(1) == kind_channels(desc_reg.kind));
        ch5      = 5'(cnt_reg);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (desc_valid) begin
                    state_next = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                if (out_free && is_last) begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        desc_next  = desc_reg;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !m_tready;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        desc_pop   = 1'b0;
        busy       = (state_reg == BK_DRAIN);
        unique case (state_reg)
            BK_IDLE: begin
                if (desc_valid) begin
                    desc_pop  = 1'b1;
                    desc_next = desc_in;
                    cnt_next  = '0;
                end
            end
            BK_DRAIN: begin
                if (out_free) begin
                    valid_next = 1'b1;
                    data_next  = {7'd0,
                                  desc_reg.mm_trigger,
                                  desc_reg.trigger,
                                  lo_mem[cnt_reg[IDX_W-1:0]],
                                  hi_mem[cnt_reg[IDX_W-1:0]],
                                  ch5,
                                  desc_reg.fee_byte[3:0],
                                  desc_reg.fee_byte[7:4]};
                    user_next  = desc_reg.kind;
                    last_next  = is_last;
                    cnt_next   = cnt_reg + CH_W'(1);
                end
            end
            default: desc_pop = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        desc_reg <= desc_next;
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
        cnt_reg  <= cnt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

FILE: rtl/detector_frame_feature_decoder.sv
// Top level of the detector frame feature decoder.
// The slave channel takes one raw stream byte per item in s_tdata. The block
// hunts for the sync word 55 AA EB 90, parses the 12-byte header and decodes
// calorimeter and crystal packets, wave or summary form.
// After the last byte of a good packet it emits one item per channel on the
// master channel; m_tuser carries the packet kind and m_tlast marks the final
// channel of the packet. Bad packets emit nothing and restart the hunt.
// Bytes are taken at one per cycle while a packet is parsed. The first
// result is registered in the descriptor queue, the back-part state and the
// output register, then results follow one per cycle while the receiver is ready.
// s_tready is low from the end of a packet until its drain is finished.
// A stall on m_tready holds the current result and lengthens the drain.
// Reset returns the parser to the sync hunt and empties the output.
`default_nettype none
module detector_frame_feature_decoder
    import dfd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte[7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // fee_id[3:0], package_class[7:4], channel[12:8], pedestal[28:13],
    // amplitude[44:29], trigger_id[56:45], mm_trigger_id[88:57]
    output logic [95:0]      m_tdata,
    output logic [1:0]       m_tuser,   // packet_kind[1:0]
    output logic             m_tlast    // last_of_packet
);

    store_wr_t store_wr;
    logic      desc_push;
    desc_t     desc_w;
    logic      q_valid;
    desc_t     q_head;
    logic      q_pop;
    logic      back_busy;
    logic      in_fire;

    assign s_tready = !q_valid && !back_busy;
    assign in_fire  = s_tvalid && s_tready;

    dfd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .store_wr  (store_wr),
        .desc_push (desc_push),
        .desc      (desc_w)
    );

    dfd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (desc_push),
        .push_desc (desc_w),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    dfd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .store_wr   (store_wr),
        .desc_valid (q_valid),
        .desc_in    (q_head),
        .desc_pop   (q_pop),
        .busy       (back_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
`default_nettype wire

FILE: tb/tb_detector_frame_feature_decoder.sv
// Self-checking testbench for the detector frame feature decoder.
`timescale 1ns / 1ps
`default_nettype none
module tb_detector_frame_feature_decoder;
    import dfd_pkg::*;

    typedef struct {
        logic [95:0] data;
        logic [1:0]  kind;
        logic        last;
    } chan_result_t;

    localparam int FLAW_NONE    = 0;
    localparam int FLAW_LENGTH  = 1;
    localparam int FLAW_TRAILER = 2;
    localparam int FLAW_KIND    = 3;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_MAX    = 1;
    localparam int FILL_ZERO   = 2;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    chan_result_t expected_channels[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    // Decoder state mirrored by the predictor.
    logic [23:0] sync_win;
    phase_t      parse_ph;
    int          byte_idx;
    logic [15:0] pkt_len;
    logic [7:0]  fee_reg;
    logic [7:0]  high_byte;
    logic [19:0] ped_sum;
    logic [15:0] peak;
    logic [31:0] chan_store[STORE_DEPTH];
    logic [11:0] trig_reg;
    logic        trl_ok;
    logic [31:0] mm_reg;
    logic [1:0]  kind_reg;

    detector_frame_feature_decoder u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic bit len_known(input logic [15:0] len);
        return len == LEN_CALO_WAVE || len == LEN_CALO_SUM ||
               len == LEN_CRY_WAVE || len == LEN_CRY_SUM;
    endfunction

    function automatic void restart_hunt();
        parse_ph = PH_HUNT;
        sync_win = '0;
        byte_idx = 0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b);
        int nch, tpos, c, j, s, o, per;
        bit wave;
        logic [15:0] v;
        logic [3:0] fee;
        chan_result_t r;
        if (parse_ph == PH_HUNT) begin
            if (sync_win == SYNC_HEAD && b == SYNC_LAST) begin
                parse_ph = PH_HEADER;
                byte_idx = 0;
            end else begin
                sync_win = {sync_win[15:0], b};
            end
            return;
        end
        if (parse_ph == PH_HEADER) begin
            j = byte_idx;
            byte_idx++;
            if (j == HDR_LEN_HI) begin
                pkt_len = {b, 8'h00};
            end else if (j == HDR_LEN_LO) begin
                pkt_len[7:0] = b;
                if (!len_known(pkt_len)) restart_hunt();
            end else if (j == HDR_FEE) begin
                fee = b[7:4];
                fee_reg = b;
                if (fee >= 5 && fee <= 8 && pkt_len == LEN_CALO_WAVE) begin
                    kind_reg = KIND_CALO_WAVE;
                end else if (fee >= 5 && fee <= 8 && pkt_len == LEN_CALO_SUM) begin
                    kind_reg = KIND_CALO_SUM;
                end else if (fee == 2 && pkt_len == LEN_CRY_WAVE) begin
                    kind_reg = KIND_CRY_WAVE;
                end else if (fee == 2 && pkt_len == LEN_CRY_SUM) begin
                    kind_reg = KIND_CRY_SUM;
                end else begin
                    restart_hunt();
                    return;
                end
                parse_ph = PH_BODY;
                byte_idx = 0;
            end
            return;
        end
        nch = kind_reg[1] ? CRYSTAL_CHANNELS : CALO_CHANNELS;
        wave = !kind_reg[0];
        per = SAMPLES_PER_CHANNEL * 2;
        tpos = wave ? nch * per : nch * 4;
        j = byte_idx;
        byte_idx++;
        if (j < tpos) begin
            if (wave) begin
                c = j / per;
                s = (j % per) >> 1;
                if (j % 2 == 0) begin
                    high_byte = b;
                end else begin
                    v = {high_byte, b};
                    if (s == 0) begin
                        ped_sum = '0;
                        peak = '0;
                    end
                    if (s < PED_COUNT) ped_sum += v;
                    if (v > peak) peak = v;
                    if (s == SAMPLES_PER_CHANNEL - 1 && c < STORE_DEPTH)
                        chan_store[c] = {16'(ped_sum / PED_COUNT), peak};
                end
            end else begin
                c = j >> 2;
                if (j % 2 == 0) begin
                    high_byte = b;
                end else if (c < STORE_DEPTH) begin
                    v = {high_byte, b};
                    if (j % 4 == 1) chan_store[c] = {v, 16'h0000};
                    else chan_store[c][15:0] = v;
                end
            end
            return;
        end
        o = j - tpos;
        if (o == TAIL_TRIG_HI) trig_reg = {b[3:0], 8'h00};
        else if (o == TAIL_TRIG_LO) trig_reg[7:0] = b;
        else if (o == TAIL_TRL_0) trl_ok = (b == TRAILER_0);
        else if (o == TAIL_TRL_1) begin
            if (wave && !(trl_ok && b == TRAILER_1)) begin
                restart_hunt();
                return;
            end
        end else if (o >= TAIL_MM_0) mm_reg = {mm_reg[23:0], b};
        if (o >= TAIL_END) begin
            for (c = 0; c < nch && c < STORE_DEPTH; c++) begin
                r.data = '0;
                r.data[3:0] = fee_reg[7:4];
                r.data[7:4] = fee_reg[3:0];
                r.data[12:8] = 5'(c);
                r.data[28:13] = chan_store[c][31:16];
                r.data[44:29] = chan_store[c][15:0];
                r.data[56:45] = trig_reg;
                r.data[88:57] = mm_reg;
                r.kind = kind_reg;
                r.last = (c + 1 == nch);
                expected_channels.push_back(r);
            end
            restart_hunt();
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_result();
        chan_result_t e;
        if (expected_channels.size() == 0) begin
            report_mismatch($sformatf("unexpected item data=%h", m_tdata));
            return;
        end
        e = expected_channels.pop_front();
        if (m_tdata !== e.data)
            report_mismatch($sformatf("data %h, predicted %h", m_tdata, e.data));
        if (m_tuser !== e.kind)
            report_mismatch($sformatf("kind %0d, predicted %0d", m_tuser, e.kind));
        if (m_tlast !== e.last)
            report_mismatch($sformatf("last %0d, predicted %0d", m_tlast, e.last));
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_result();
    end

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b);
    endtask

    function automatic logic [15:0] fill_word(input int fill);
        if (fill == FILL_MAX) return 16'hFFFF;
        if (fill == FILL_ZERO) return 16'h0000;
        return 16'($urandom);
    endfunction

    task automatic send_packet(input logic [7:0] fee_b, input logic [1:0] knd,
                               input int flaw, input int fill);
        logic [7:0] pkt[$];
        logic [15:0] len, w;
        int nch, n;
        bit drop;
        nch = knd[1] ? CRYSTAL_CHANNELS : CALO_CHANNELS;
        n = knd[0] ? nch * 2 : nch * SAMPLES_PER_CHANNEL;
        case (knd)
            KIND_CALO_WAVE: len = LEN_CALO_WAVE;
            KIND_CALO_SUM:  len = LEN_CALO_SUM;
            KIND_CRY_WAVE:  len = LEN_CRY_WAVE;
            default:        len = LEN_CRY_SUM;
        endcase
        if (flaw == FLAW_LENGTH) len = len ^ 16'(1 << $urandom_range(15));
        if (flaw == FLAW_KIND) len = knd[1] ? LEN_CALO_SUM : LEN_CRY_SUM;
        drop = (flaw == FLAW_LENGTH) || (flaw == FLAW_KIND) ||
               !(fee_b[7:4] == 4'd2 || (fee_b[7:4] >= 4'd5 && fee_b[7:4] <= 4'd8));
        pkt = '{8'h55, 8'hAA, 8'hEB, 8'h90};
        for (int i = 0; i < 12; i++) begin
            if (i == HDR_LEN_HI) pkt.push_back(len[15:8]);
            else if (i == HDR_LEN_LO) pkt.push_back(len[7:0]);
            else if (i == HDR_FEE) pkt.push_back(fee_b);
            else pkt.push_back(8'($urandom));
        end
        if (!drop) begin
            for (int i = 0; i < n; i++) begin
                w = fill_word(fill);
                pkt.push_back(w[15:8]);
                pkt.push_back(w[7:0]);
            end
            for (int i = 0; i < 12; i++) begin
                if (i == TAIL_TRL_0) pkt.push_back(TRAILER_0);
                else if (i == TAIL_TRL_1)
                    pkt.push_back(flaw == FLAW_TRAILER ? 8'($urandom_range(255, 166))
                                                       : TRAILER_1);
                else pkt.push_back(8'($urandom));
            end
        end
        foreach (pkt[i]) send_byte(pkt[i]);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_channels.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    function automatic logic [7:0] good_fee(input logic [1:0] knd);
        return {knd[1] ? 4'd2 : 4'($urandom_range(8, 5)), 4'($urandom)};
    endfunction

    task automatic test_sync_and_rejects();
        send_byte(8'h55);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(8'hEB);
        send_byte(8'hEB);
        send_packet(8'h5F, KIND_CALO_SUM, FLAW_LENGTH, FILL_RANDOM);
        send_packet(8'h30, KIND_CALO_SUM, FLAW_NONE, FILL_RANDOM);
        send_packet(8'h2A, KIND_CRY_SUM, FLAW_KIND, FILL_RANDOM);
        send_packet(8'h90, KIND_CRY_SUM, FLAW_NONE, FILL_RANDOM);
        wait_drained();
    endtask

    task automatic test_packet_kinds();
        send_packet(8'h50, KIND_CALO_SUM, FLAW_NONE, FILL_MAX);
        send_packet(8'h2F, KIND_CRY_SUM, FLAW_NONE, FILL_ZERO);
        wait_drained();
    endtask

    task automatic test_random_stream(input int packets);
        for (int p = 0; p < packets; p++) begin
            send_packet(good_fee(KIND_CRY_SUM), KIND_CRY_SUM, FLAW_NONE, FILL_RANDOM);
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        hold_cycles = 400;
        send_packet(good_fee(KIND_CRY_SUM), KIND_CRY_SUM, FLAW_NONE, FILL_RANDOM);
        repeat (2) send_byte(8'($urandom));
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_sync_and_rejects();
        test_packet_kinds();
        send_idle_pct = 50;
        test_random_stream(1);
        send_idle_pct = 0;
        recv_stall_pct = 50;
        test_output_backpressure();
        send_idle_pct = 13;
        recv_stall_pct = 13;
        test_random_stream(1);
        wait_drained();
        if (errors == 0) begin
            $display("detector_frame_feature_decoder regression: pass");
        end else begin
            $display("detector_frame_feature_decoder regression: fail");
        end
        $finish;
    end

    initial begin
        restart_hunt();
        pkt_len = '0;
        fee_reg = '0;
        high_byte = '0;
        ped_sum = '0;
        peak = '0;
        trig_reg = '0;
        trl_ok = 1'b0;
        mm_reg = '0;
        kind_reg = '0;
        #20ms;
        $display("detector_frame_feature_decoder regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
